/* hw/rtl/vcrm_pkg.sv */
// Package for the voice call record mixer: ring geometry, command codes,
// payload words and the stage structs shared by the mixer modules.
// No dependencies.
package vcrm_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 32;
    localparam int RL_W       = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CMP_W      = (ADDR_W + 1 > RL_W) ? ADDR_W + 1 : RL_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RING_LENGTH   = CFG_IDX_W'(1);
    localparam logic [RL_W-1:0]      RING_LENGTH_RESET = RL_W'(4096);

    typedef enum logic [1:0] {
        CMD_UP_WRITE   = 2'd0,
        CMD_DOWN_WRITE = 2'd1,
        CMD_READ       = 2'd2,
        CMD_RESTART    = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic signed [SAMPLE_W-1:0] sample;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] read_sample;
        logic                       read_valid;
    } out_word_t;

    typedef struct packed {
        logic                       is_write;
        logic                       is_read;
        logic                       mix;
        logic                       hit;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] sample;
    } op_t;

    typedef struct packed {
        logic read_in_flight;
        logic out_stall;
    } dp_status_t;

    function automatic logic [CMP_W-1:0] eff_length(input logic [RL_W-1:0] len);
        logic [CMP_W-1:0] n;
        n = CMP_W'(len);
        if (n == '0)
        begin
            n = CMP_W'(1);
        end
        if (n > CMP_W'(RING_DEPTH))
        begin
            n = CMP_W'(RING_DEPTH);
        end
        return n;
    endfunction

    function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a,
                                                    input logic [CMP_W-1:0]  len);
        logic [CMP_W-1:0] n;
        n = CMP_W'(a) + CMP_W'(1);
        return (n >= len) ? '0 : n[ADDR_W-1:0];
    endfunction

endpackage

/* hw/rtl/voice_call_record_mixer_unit.sv */
// Voice call record mixer: uplink and downlink samples mixed into one ring.
// A read word passes through the op register and then the result register before its result is presented.
// Throughput: one word a cycle; a read blocks the next word while it is in flight,
// and a read waits while an earlier result is still held.
// Reset clears all counts and addresses, disables recording and sets the
// ring length to 4096; ring contents are undefined until written.
module voice_call_record_mixer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  vcrm_pkg::in_word_t             item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output vcrm_pkg::out_word_t            result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vcrm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vcrm_pkg::RL_W-1:0]      cfg_data
);

    vcrm_pkg::op_t                 op;
    vcrm_pkg::dp_status_t          status;
    logic                          rd_en;
    logic [vcrm_pkg::ADDR_W-1:0]   rd_addr;
    logic [vcrm_pkg::SAMPLE_W-1:0] rd_data;
    logic                          wr_en;
    logic [vcrm_pkg::ADDR_W-1:0]   wr_addr;
    logic [vcrm_pkg::SAMPLE_W-1:0] wr_data;

    vcrm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .status     (status),
        .op         (op),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr)
    );

    vcrm_ram #(
        .WIDTH (vcrm_pkg::SAMPLE_W),
        .DEPTH (vcrm_pkg::RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    vcrm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .ram_rdata    (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* hw/rtl/vcrm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module vcrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/vcrm_ctrl.sv */
// Issue stage of the mixer: configuration registers, stream and read counts,
// ring addresses and the mix decision. Depends on vcrm_pkg.
module vcrm_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  vcrm_pkg::in_word_t            item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vcrm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vcrm_pkg::RL_W-1:0]     cfg_data,
    input  vcrm_pkg::dp_status_t          status,
    output vcrm_pkg::op_t                 op,
    output logic                          rd_en,
    output logic [vcrm_pkg::ADDR_W-1:0]   rd_addr
);

    logic                          enable_reg;
    logic [vcrm_pkg::RL_W-1:0]     length_reg;
    logic [vcrm_pkg::COUNT_W-1:0]  up_count_reg, up_count_next;
    logic [vcrm_pkg::COUNT_W-1:0]  down_count_reg, down_count_next;
    logic [vcrm_pkg::COUNT_W-1:0]  mixed_count_reg, mixed_count_next;
    logic [vcrm_pkg::COUNT_W-1:0]  read_count_reg, read_count_next;
    logic [vcrm_pkg::ADDR_W-1:0]   up_addr_reg, up_addr_next;
    logic [vcrm_pkg::ADDR_W-1:0]   down_addr_reg, down_addr_next;
    logic [vcrm_pkg::ADDR_W-1:0]   read_addr_reg, read_addr_next;
    logic [vcrm_pkg::CMP_W-1:0]    len_eff;
    logic [vcrm_pkg::COUNT_W-1:0]  up_diff, down_diff, read_diff;
    logic                          accept;

    assign cfg_ready  = 1'b1;
    assign item_ready = !status.read_in_flight
                        && !(status.out_stall && item.cmd == vcrm_pkg::CMD_READ);
    assign accept     = item_valid && item_ready;
    assign len_eff    = vcrm_pkg::eff_length(length_reg);
    assign up_diff    = up_count_reg - down_count_reg;
    assign down_diff  = down_count_reg - up_count_reg;
    assign read_diff  = mixed_count_reg - read_count_reg;

    always_comb
    begin
        up_count_next    = up_count_reg;
        down_count_next  = down_count_reg;
        mixed_count_next = mixed_count_reg;
        read_count_next  = read_count_reg;
        up_addr_next     = up_addr_reg;
        down_addr_next   = down_addr_reg;
        read_addr_next   = read_addr_reg;
        op               = '0;
        op.sample        = item.sample;
        rd_en            = 1'b0;
        rd_addr          = read_addr_reg;
        if (accept)
        begin
            case (item.cmd)
                vcrm_pkg::CMD_UP_WRITE:
                begin
                    if (enable_reg)
                    begin
                        op.is_write      = 1'b1;
                        op.mix           = up_diff[vcrm_pkg::COUNT_W-1];
                        op.addr          = up_addr_reg;
                        rd_en            = op.mix;
                        rd_addr          = up_addr_reg;
                        mixed_count_next = mixed_count_reg
                                           + vcrm_pkg::COUNT_W'(op.mix);
                        up_count_next    = up_count_reg + vcrm_pkg::COUNT_W'(1);
                        up_addr_next     = vcrm_pkg::next_addr(up_addr_reg, len_eff);
                    end
                end
                vcrm_pkg::CMD_DOWN_WRITE:
                begin
                    if (enable_reg)
                    begin
                        op.is_write      = 1'b1;
                        op.mix           = down_diff[vcrm_pkg::COUNT_W-1];
                        op.addr          = down_addr_reg;
                        rd_en            = op.mix;
                        rd_addr          = down_addr_reg;
                        mixed_count_next = mixed_count_reg
                                           + vcrm_pkg::COUNT_W'(op.mix);
                        down_count_next  = down_count_reg + vcrm_pkg::COUNT_W'(1);
                        down_addr_next   = vcrm_pkg::next_addr(down_addr_reg, len_eff);
                    end
                end
                vcrm_pkg::CMD_READ:
                begin
                    op.is_read = 1'b1;
                    op.hit     = enable_reg && (read_diff != '0)
                                 && !read_diff[vcrm_pkg::COUNT_W-1];
                    op.addr    = read_addr_reg;
                    rd_en      = op.hit;
                    if (op.hit)
                    begin
                        read_count_next = read_count_reg + vcrm_pkg::COUNT_W'(1);
                        read_addr_next  = vcrm_pkg::next_addr(read_addr_reg, len_eff);
                    end
                end
                default:
                begin
                    up_count_next    = '0;
                    down_count_next  = '0;
                    mixed_count_next = '0;
                    read_count_next  = '0;
                    up_addr_next     = '0;
                    down_addr_next   = '0;
                    read_addr_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            length_reg      <= vcrm_pkg::RING_LENGTH_RESET;
            up_count_reg    <= '0;
            down_count_reg  <= '0;
            mixed_count_reg <= '0;
            read_count_reg  <= '0;
            up_addr_reg     <= '0;
            down_addr_reg   <= '0;
            read_addr_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == vcrm_pkg::CFG_RECORD_ENABLE)
                begin
                    enable_reg <= cfg_data[0];
                end
                else if (cfg_index == vcrm_pkg::CFG_RING_LENGTH)
                begin
                    length_reg <= cfg_data;
                end
            end
            up_count_reg    <= up_count_next;
            down_count_reg  <= down_count_next;
            mixed_count_reg <= mixed_count_next;
            read_count_reg  <= read_count_next;
            up_addr_reg     <= up_addr_next;
            down_addr_reg   <= down_addr_next;
            read_addr_reg   <= read_addr_next;
        end
    end

`ifndef ASSERT_OFF
    a_read_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        vcrm_pkg::CMP_W'(read_addr_reg) < vcrm_pkg::CMP_W'(vcrm_pkg::RING_DEPTH))
        else $error("read address beyond ring");
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.cmd == vcrm_pkg::CMD_RESTART |=> mixed_count_reg == '0
        && read_addr_reg == '0)
        else $error("restart did not clear counts");
    a_no_ram_read_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> !rd_en)
        else $error("ring read without an accepted word");
`endif

endmodule

/* hw/rtl/vcrm_datapath.sv */
// Write-back stage of the mixer: forwarding, averaging, ring write and the
// result register. Depends on vcrm_pkg.
module vcrm_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  vcrm_pkg::op_t                   op,
    input  logic                            rd_en,
    input  logic [vcrm_pkg::ADDR_W-1:0]     rd_addr,
    input  logic [vcrm_pkg::SAMPLE_W-1:0]   ram_rdata,
    output logic                            wr_en,
    output logic [vcrm_pkg::ADDR_W-1:0]     wr_addr,
    output logic [vcrm_pkg::SAMPLE_W-1:0]   wr_data,
    output vcrm_pkg::dp_status_t            status,
    output logic                            result_valid,
    input  logic                            result_ready,
    output vcrm_pkg::out_word_t             result
);

    vcrm_pkg::op_t                   op_reg;
    logic                            fwd_hit_reg;
    logic [vcrm_pkg::SAMPLE_W-1:0]   fwd_data_reg;
    logic                            out_valid_reg;
    vcrm_pkg::out_word_t             out_reg;
    logic [vcrm_pkg::SAMPLE_W-1:0]   stored;
    logic signed [vcrm_pkg::SAMPLE_W:0] sum;
    logic signed [vcrm_pkg::SAMPLE_W:0] adj;

    assign stored  = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign sum     = {stored[vcrm_pkg::SAMPLE_W-1], stored}
                     + {op_reg.sample[vcrm_pkg::SAMPLE_W-1], op_reg.sample};
    assign adj     = sum + {{vcrm_pkg::SAMPLE_W{1'b0}}, sum[vcrm_pkg::SAMPLE_W]};
    assign wr_en   = op_reg.is_write;
    assign wr_addr = op_reg.addr;
    assign wr_data = op_reg.mix ? adj[vcrm_pkg::SAMPLE_W:1] : op_reg.sample;

    assign status.read_in_flight = op_reg.is_read;
    assign status.out_stall      = out_valid_reg && !result_ready;
    assign result_valid          = out_valid_reg;
    assign result                = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= '0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            op_reg      <= op;
            fwd_hit_reg <= rd_en && wr_en && (rd_addr == wr_addr);
            if (op_reg.is_read)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr_data;
        if (op_reg.is_read)
        begin
            out_reg.read_valid  <= op_reg.hit;
            out_reg.read_sample <= op_reg.hit ? stored : '0;
        end
    end

`ifndef ASSERT_OFF
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        op_reg.is_read |-> !(out_valid_reg && !result_ready))
        else $error("result register overwritten before it was taken");
    a_fwd_only_for_reads: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> (op_reg.mix || op_reg.hit))
        else $error("forwarded data without a ring read");
    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.read_valid |-> out_reg.read_sample == '0)
        else $error("empty result carries a nonzero sample");
`endif

endmodule

/* verif/vcrm_mix_checker.sv */
`timescale 1ns / 1ps
// Checker for the voice call record mixer: watches the item, result and register
// channels, keeps its own copy of the ring and counts, and compares every read word.
// Depends on vcrm_pkg for the word types, command codes and register indexes.
module vcrm_mix_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  logic                           item_ready,
    input  vcrm_pkg::in_word_t             item,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  vcrm_pkg::out_word_t            result,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [vcrm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vcrm_pkg::RL_W-1:0]      cfg_data,
    output int                             fail_count,
    output int                             reads_waiting,
    output int                             words_seen,
    output int                             reads_checked,
    output int                             valid_reads
);

    localparam int DEPTH = vcrm_pkg::RING_DEPTH;
    localparam int AW    = vcrm_pkg::ADDR_W;

    logic signed [15:0]        ring_mem [DEPTH];
    logic [31:0]               up_cnt;
    logic [31:0]               down_cnt;
    logic [31:0]               mix_cnt;
    logic [31:0]               rd_cnt;
    logic [AW-1:0]             up_ptr;
    logic [AW-1:0]             down_ptr;
    logic [AW-1:0]             rd_ptr;
    logic                      rec_en;
    logic [vcrm_pkg::RL_W-1:0] ring_len;
    vcrm_pkg::out_word_t       read_results_due [$];

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] ptr);
        int unsigned span;
        int unsigned nxt;
        if (ring_len == '0)
        begin
            span = 1;
        end
        else if (ring_len > DEPTH)
        begin
            span = DEPTH;
        end
        else
        begin
            span = 32'(ring_len);
        end
        nxt = 32'(ptr) + 1;
        return (nxt >= span) ? '0 : AW'(nxt);
    endfunction

    task automatic restart_counts();
        up_cnt   = '0;
        down_cnt = '0;
        mix_cnt  = '0;
        rd_cnt   = '0;
        up_ptr   = '0;
        down_ptr = '0;
        rd_ptr   = '0;
    endtask

    // A stream level with or ahead of the other copies its sample; one behind averages.
    task automatic mix_sample(input logic downlink, input logic signed [15:0] smp);
        logic [31:0]   lead;
        logic [AW-1:0] ptr;
        int            avg;
        ptr  = downlink ? down_ptr : up_ptr;
        lead = downlink ? down_cnt - up_cnt : up_cnt - down_cnt;
        if (!lead[31])
        begin
            ring_mem[ptr] = smp;
        end
        else
        begin
            avg = (int'(ring_mem[ptr]) + int'(smp)) / 2;
            ring_mem[ptr] = avg[15:0];
            mix_cnt = mix_cnt + 1;
        end
        if (downlink)
        begin
            down_cnt = down_cnt + 1;
            down_ptr = advance(down_ptr);
        end
        else
        begin
            up_cnt = up_cnt + 1;
            up_ptr = advance(up_ptr);
        end
    endtask

    task automatic apply_command(input vcrm_pkg::in_word_t w);
        vcrm_pkg::out_word_t want;
        logic [31:0]         backlog;
        case (vcrm_pkg::cmd_t'(w.cmd))
            vcrm_pkg::CMD_UP_WRITE:
            begin
                if (rec_en)
                begin
                    mix_sample(1'b0, w.sample);
                end
            end
            vcrm_pkg::CMD_DOWN_WRITE:
            begin
                if (rec_en)
                begin
                    mix_sample(1'b1, w.sample);
                end
            end
            vcrm_pkg::CMD_READ:
            begin
                want    = '0;
                backlog = mix_cnt - rd_cnt;
                if (rec_en && backlog != '0 && !backlog[31])
                begin
                    want.read_sample = ring_mem[rd_ptr];
                    want.read_valid  = 1'b1;
                    rd_cnt = rd_cnt + 1;
                    rd_ptr = advance(rd_ptr);
                end
                read_results_due.push_back(want);
            end
            default:
            begin
                restart_counts();
            end
        endcase
    endtask

    task automatic check_result(input vcrm_pkg::out_word_t got);
        vcrm_pkg::out_word_t want;
        if (read_results_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("Result word with no read pending: sample %0d valid %0b",
                         got.read_sample, got.read_valid);
            end
        end
        else
        begin
            want = read_results_due.pop_front();
            reads_checked++;
            if (want.read_valid)
            begin
                valid_reads++;
            end
            if (got.read_sample !== want.read_sample ||
                got.read_valid !== want.read_valid)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display({"Read word %0d mismatch: expected sample %0d valid %0b, ",
                              "got sample %0d valid %0b"},
                             reads_checked, want.read_sample, want.read_valid,
                             got.read_sample, got.read_valid);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_counts();
            rec_en        = 1'b0;
            ring_len      = vcrm_pkg::RING_LENGTH_RESET;
            read_results_due.delete();
            fail_count    = 0;
            words_seen    = 0;
            reads_checked = 0;
            valid_reads   = 0;
        end
        else
        begin
            // A word taken at the same edge as a register write still sees the old value.
            if (item_valid && item_ready)
            begin
                apply_command(item);
                words_seen++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    vcrm_pkg::CFG_RECORD_ENABLE: rec_en = cfg_data[0];
                    vcrm_pkg::CFG_RING_LENGTH:   ring_len = cfg_data;
                    default: ;
                endcase
            end
            if (result_valid && result_ready)
            begin
                check_result(result);
            end
        end
        reads_waiting = read_results_due.size();
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Top of the voice call record mixer testbench: clock, reset, stimulus and verdict.
// Depends on vcrm_pkg, voice_call_record_mixer_unit and vcrm_mix_checker.
module tb_top;

    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASES        = 10;
    localparam int PHASE_WORDS   = 20;
    localparam int PREFILL_WORDS = 256;

    localparam logic [vcrm_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = vcrm_pkg::CFG_IDX_W'(2);
    localparam logic [vcrm_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = vcrm_pkg::CFG_IDX_W'(3);

    typedef enum int {
        RDY_OPEN,
        RDY_COIN,
        RDY_ONE_IN_FOUR,
        RDY_LONG_STALL
    } ready_mode_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           item_valid;
    logic                           item_ready;
    vcrm_pkg::in_word_t             item;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    vcrm_pkg::out_word_t            result;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [vcrm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [vcrm_pkg::RL_W-1:0]      cfg_data;

    int fail_count;
    int reads_waiting;
    int words_seen;
    int reads_checked;
    int valid_reads;

    int          burst_left = 0;
    bit          no_gaps = 1'b0;
    int          regs_written = 0;
    int          quiet_cycles = 0;
    int          ready_tick = 0;
    int          stall_left = 0;
    ready_mode_t ready_mode = RDY_OPEN;

    always #5 clk = ~clk;

    voice_call_record_mixer_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    vcrm_mix_checker mix_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .reads_waiting (reads_waiting),
        .words_seen    (words_seen),
        .reads_checked (reads_checked),
        .valid_reads   (valid_reads)
    );

    always @(negedge clk)
    begin
        ready_tick = ready_tick + 1;
        if (ready_tick % 64 == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
        end
        case (ready_mode)
            RDY_OPEN:        result_ready = 1'b1;
            RDY_COIN:        result_ready = 1'($urandom_range(0, 1));
            RDY_ONE_IN_FOUR: result_ready = (ready_tick % 4 == 0);
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left   = stall_left - 1;
                    result_ready = 1'b0;
                end
                else
                begin
                    stall_left   = $urandom_range(0, 10);
                    result_ready = 1'b1;
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] any_sample();
        if ($urandom_range(0, 6) != 0)
        begin
            return 16'($urandom);
        end
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h0001;
            default: return 16'hFFFE;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input vcrm_pkg::cmd_t c, input logic [15:0] s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                item_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left  = burst_left - 1;
        item.cmd    = c;
        item.sample = s;
        item_valid  = 1'b1;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic settle();
        item_valid = 1'b0;
        while (reads_waiting != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [vcrm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vcrm_pkg::RL_W-1:0] data);
        settle();
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid    = 1'b0;
        regs_written = regs_written + 1;
    endtask

    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 37)
        begin
            send_word(vcrm_pkg::CMD_UP_WRITE, any_sample());
        end
        else if (pick < 74)
        begin
            send_word(vcrm_pkg::CMD_DOWN_WRITE, any_sample());
        end
        else if (pick < 97)
        begin
            send_word(vcrm_pkg::CMD_READ, 16'($urandom));
        end
        else
        begin
            send_word(vcrm_pkg::CMD_RESTART, 16'($urandom));
        end
    endtask

    initial
    begin
        logic [vcrm_pkg::RL_W-1:0] len;
        logic                      en;
        item_valid = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // The low ring entries are written once; fewer words follow than there are
        // entries here, so no address can step past them to unwritten data.
        write_reg(vcrm_pkg::CFG_RECORD_ENABLE, vcrm_pkg::RL_W'(1));
        write_reg(vcrm_pkg::CFG_RING_LENGTH, vcrm_pkg::RL_W'(4096));
        no_gaps = 1'b1;
        for (int i = 0; i < PREFILL_WORDS; i++)
        begin
            send_word(vcrm_pkg::CMD_UP_WRITE, any_sample());
        end
        send_word(vcrm_pkg::CMD_RESTART, 16'hFFFF);
        no_gaps = 1'b0;

        send_word(vcrm_pkg::CMD_READ, 16'h0000);
        send_word(vcrm_pkg::CMD_UP_WRITE, 16'h7FFF);
        send_word(vcrm_pkg::CMD_DOWN_WRITE, 16'h8000);
        send_word(vcrm_pkg::CMD_READ, 16'hFFFF);
        send_word(vcrm_pkg::CMD_UP_WRITE, 16'h8000);
        send_word(vcrm_pkg::CMD_DOWN_WRITE, 16'h8000);
        send_word(vcrm_pkg::CMD_DOWN_WRITE, 16'h7FFF);
        send_word(vcrm_pkg::CMD_UP_WRITE, 16'h7FFF);
        send_word(vcrm_pkg::CMD_UP_WRITE, 16'hFFFF);
        send_word(vcrm_pkg::CMD_DOWN_WRITE, 16'h0000);
        send_word(vcrm_pkg::CMD_UP_WRITE, 16'h0001);
        send_word(vcrm_pkg::CMD_DOWN_WRITE, 16'hFFFE);
        send_word(vcrm_pkg::CMD_UP_WRITE, 16'hFFFD);
        send_word(vcrm_pkg::CMD_DOWN_WRITE, 16'h0000);
        for (int i = 0; i < 6; i++)
        begin
            send_word(vcrm_pkg::CMD_READ, 16'h5A5A);
        end
        send_word(vcrm_pkg::CMD_UP_WRITE, 16'h1234);
        send_word(vcrm_pkg::CMD_RESTART, 16'h0000);
        send_word(vcrm_pkg::CMD_READ, 16'h0000);
        write_reg(vcrm_pkg::CFG_RECORD_ENABLE, vcrm_pkg::RL_W'(0));
        send_word(vcrm_pkg::CMD_DOWN_WRITE, 16'h4321);
        send_word(vcrm_pkg::CMD_READ, 16'h0000);
        send_word(vcrm_pkg::CMD_RESTART, 16'h0000);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       len = vcrm_pkg::RL_W'(1);
                1:       len = vcrm_pkg::RL_W'(2);
                2:       len = vcrm_pkg::RL_W'(0);
                3:       len = vcrm_pkg::RL_W'(3);
                4:       len = vcrm_pkg::RL_W'(4096);
                5:       len = vcrm_pkg::RL_W'(8191);
                6:       len = vcrm_pkg::RL_W'($urandom_range(4, 40));
                7:       len = vcrm_pkg::RL_W'($urandom_range(4097, 8191));
                8:       len = vcrm_pkg::RL_W'($urandom_range(1, 4096));
                default: len = vcrm_pkg::RL_W'($urandom_range(5, 17));
            endcase
            en = (phase != 3);
            write_reg(vcrm_pkg::CFG_RECORD_ENABLE, vcrm_pkg::RL_W'(en));
            write_reg(vcrm_pkg::CFG_RING_LENGTH, len);
            if (phase == 2)
            begin
                write_reg(CFG_SPARE_A, 13'($urandom));
            end
            if (phase == 5)
            begin
                write_reg(CFG_SPARE_B, 13'($urandom));
            end
            no_gaps = (phase == 4 || phase == 8);
            // Phase six keeps the old addresses so some sit beyond the shrunken ring.
            if (phase != 6 && $urandom_range(0, 1) == 1)
            begin
                send_word(vcrm_pkg::CMD_RESTART, 16'($urandom));
            end
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                random_word();
            end
        end

        settle();
        repeat (4) @(negedge clk);
        $display("Run covered %0d input words and %0d register writes over %0d ring settings.",
                 words_seen, regs_written, PHASES);
        $display("Checked %0d read results, %0d of them carrying mixed samples.",
                 reads_checked, valid_reads);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* voice_call_record_mixer_unit.f */
hw/rtl/vcrm_pkg.sv
hw/rtl/vcrm_ram.sv
hw/rtl/vcrm_ctrl.sv
hw/rtl/vcrm_datapath.sv
hw/rtl/voice_call_record_mixer_unit.sv
verif/vcrm_mix_checker.sv
verif/tb_top.sv
